### design/chc_pkg.sv
package chc_pkg;

  localparam int Buckets     = 64;
  localparam int KeyChars    = 15;
  localparam int PoolEntries = 256;

  localparam int BucketBits = $clog2(Buckets);
  localparam int NodeBits   = $clog2(PoolEntries);
  localparam int PtrBits    = NodeBits + 1;

  localparam logic [PtrBits-1:0] NullPtr = PtrBits'(PoolEntries);
  localparam logic [63:0]        HashSeed = 64'd5381;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Node record held in the pool memory.
  typedef struct packed {
    logic [63:0]        key_low;
    logic [55:0]        key_high;
    logic [3:0]         length;
    logic [31:0]        id;
    logic [PtrBits-1:0] next;
  } node_t;

endpackage

### design/chc_hash.sv
// Normalises a key and hashes it one character per cycle.
module chc_hash
  import chc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [63:0]           key_low_in,
  input  logic [55:0]           key_high_in,
  input  logic [3:0]            key_length_in,
  output logic                  done,
  output logic [63:0]           key_low,
  output logic [55:0]           key_high,
  output logic [3:0]            key_length,
  output logic [BucketBits-1:0] bucket
);

  logic [119:0] raw;
  logic [119:0] norm;
  logic [119:0] key_cat;
  logic [3:0]   len_lim;
  logic [3:0]   len_eff;
  logic         stop;
  logic [63:0]  acc;
  logic [3:0]   pos;
  logic         busy;
  logic [7:0]   ch;

  assign raw = {key_high_in, key_low_in};

  // Cut at the length limit and at the first zero character.
  always_comb begin
    len_lim = (key_length_in > 4'(KeyChars)) ? 4'(KeyChars) : key_length_in;
    len_eff = len_lim;
    stop    = 1'b0;
    norm    = '0;
    for (int i = 0; i < 15; i++) begin
      if (!stop && (4'(i) < len_lim)) begin
        if (raw[8*i +: 8] == 8'd0) begin
          stop    = 1'b1;
          len_eff = 4'(i);
        end else begin
          norm[8*i +: 8] = raw[8*i +: 8];
        end
      end
    end
  end

  assign key_cat = {key_high, key_low};
  assign ch      = key_cat[{pos, 3'b000} +: 8];
  assign bucket  = acc[BucketBits-1:0];

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy       <= 1'b1;
      key_low    <= norm[63:0];
      key_high   <= norm[119:64];
      key_length <= len_eff;
      acc        <= HashSeed;
      pos        <= '0;
    end else if (busy) begin
      if (pos == key_length) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        acc <= (acc << 5) - acc + 64'(ch);
        pos <= pos + 4'd1;
      end
    end
  end

endmodule

### design/chained_hash_cache_top.sv
// Channel  | Direction | Payload
// s_axis   | in        | tdata: operation, key_chars_low, key_chars_high, key_length, flow_id
// m_axis   | out       | tdata: status, found_id, entry_count
//
// A search or insert is taken and hashed one key character at a time, then the
// bucket head is read; each chain node visited takes a memory read and a compare,
// a miss also reads the end of chain, and then come a write-back and a hand-off.
// Reset is synchronous; the head table is cleared by a sweep over all Buckets
// entries after reset and on each clear operation, during which no item is taken.
// A result waits in the output register; the next item is taken meanwhile.
module chained_hash_cache_top
  import chc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [1:0] operation, [65:2] key_chars_low, [121:66] key_chars_high,
  // [125:122] key_length, [157:126] flow_id, rest zero
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] status, [33:2] found_id, [42:34] entry_count, rest zero
  output logic [47:0]  m_axis_tdata
);

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_HASH, S_HEAD, S_READ, S_CMP, S_WRITE, S_DONE
  } state_t;

  state_t state;

  // Bucket head table and node pool memories.
  logic [PtrBits-1:0] head_mem [Buckets];
  node_t              pool_mem [PoolEntries];
  logic [PtrBits-1:0] head_rd;
  node_t              node_rd;

  logic [BucketBits-1:0] sweep;
  op_t                   op;
  logic [31:0]           pid;
  logic [PtrBits-1:0]    cur;
  logic [PtrBits-1:0]    used;
  logic [PtrBits-1:0]    hops;

  logic                  hash_start, hash_done;
  logic [63:0]           k_low;
  logic [55:0]           k_high;
  logic [3:0]            k_len;
  logic [BucketBits-1:0] bkt;

  logic        out_full;
  logic [1:0]  o_status;
  logic [31:0] o_id;
  logic [8:0]  o_count;

  // Result of the item in progress, handed to the output register when it is free.
  logic [1:0]  res_status;
  logic [31:0] res_id;
  logic [8:0]  res_count;

  logic accept;
  logic match;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign hash_start    = accept;
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {5'd0, o_count, o_id, o_status};

  assign match = (node_rd.key_low == k_low) && (node_rd.key_high == k_high) &&
                 (node_rd.length == k_len);

  chc_hash u_hash (
    .clk          (clk),
    .rst          (rst),
    .start        (hash_start),
    .key_low_in   (s_axis_tdata[65:2]),
    .key_high_in  (s_axis_tdata[121:66]),
    .key_length_in(s_axis_tdata[125:122]),
    .done         (hash_done),
    .key_low      (k_low),
    .key_high     (k_high),
    .key_length   (k_len),
    .bucket       (bkt)
  );

  always_ff @(posedge clk) begin
    head_rd <= head_mem[bkt];
    node_rd <= pool_mem[cur[NodeBits-1:0]];
    if (state == S_SWEEP) begin
      head_mem[sweep] <= NullPtr;
    end else if (state == S_WRITE && op == OP_INSERT && cur == NullPtr
                 && used != PtrBits'(PoolEntries)) begin
      head_mem[bkt] <= used;
    end
    if (state == S_WRITE && op == OP_INSERT) begin
      if (cur != NullPtr) begin
        pool_mem[cur[NodeBits-1:0]] <= '{node_rd.key_low, node_rd.key_high,
                                         node_rd.length, pid, node_rd.next};
      end else if (used != PtrBits'(PoolEntries)) begin
        pool_mem[used[NodeBits-1:0]] <= '{k_low, k_high, k_len, pid, head_rd};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_SWEEP;
      sweep    <= '0;
      used     <= '0;
      out_full <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_full || m_axis_tready)) begin
        out_full <= 1'b1;
      end else if (m_axis_tready) begin
        out_full <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep <= sweep + 1'b1;
          if (sweep == BucketBits'(Buckets - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op    <= op_t'(s_axis_tdata[1:0]);
            pid   <= s_axis_tdata[157:126];
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          // head_rd now holds the chain head of the bucket.
          unique case (op)
            OP_INSERT, OP_SEARCH: begin
              cur   <= head_rd;
              hops  <= '0;
              state <= S_READ;
            end
            OP_CLEAR: begin
              used       <= '0;
              sweep      <= '0;
              res_status <= ST_OK;
              res_id     <= '0;
              res_count  <= '0;
              state      <= S_DONE;
            end
            default: begin
              res_status <= ST_OK;
              res_id     <= '0;
              res_count  <= 9'(used);
              state      <= S_DONE;
            end
          endcase
        end
        S_READ: begin
          if (cur == NullPtr || hops == PtrBits'(PoolEntries)) begin
            cur   <= NullPtr;
            state <= S_WRITE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (match) begin
            state <= S_WRITE;
          end else begin
            cur   <= node_rd.next;
            hops  <= hops + 1'b1;
            state <= S_READ;
          end
        end
        S_WRITE: begin
          res_id     <= '0;
          res_status <= ST_OK;
          res_count  <= 9'(used);
          if (op == OP_SEARCH) begin
            if (cur != NullPtr) begin
              res_id <= node_rd.id;
            end else begin
              res_status <= ST_MISS;
            end
          end else if (cur == NullPtr) begin
            if (used == PtrBits'(PoolEntries)) begin
              res_status <= ST_FULL;
            end else begin
              used      <= used + 1'b1;
              res_count <= 9'(used + 1'b1);
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_full || m_axis_tready) begin
            o_status <= res_status;
            o_id     <= res_id;
            o_count  <= res_count;
            state    <= (op == OP_CLEAR) ? S_SWEEP : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/chc_checker.sv
module chc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [47:0]  m_axis_tdata
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Status code three is never produced.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("bad status");

  // Only a hit carries an id.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[33:2] == 32'd0)
    else $error("id on a miss or refusal");

  // Count never exceeds the pool size.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[42:34] <= 9'd256)
    else $error("count out of range");

  // No input is taken in the cycle after an acceptance.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back to back acceptance");

endmodule

bind chained_hash_cache_top chc_checker u_chc_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
